>>> hdl/mma_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the matrix multiply-accumulate block:
// transaction payloads, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package mma_pkg;

    // store geometry: 8 x 8 elements, addressed as {row, col}
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    // c << 8 plus up to eight full products, with sign
    localparam int ACC_W  = 36;
    localparam int SIZE_W = 4;
    localparam int FRAC_W = 8;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -16'sh8000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROWS_M  = 2'd0,
        CFG_DEPTH_K = 2'd1,
        CFG_COLS_N  = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_LOAD_C = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     operation;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_C,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             wr_c;
        logic             rd_c;
        logic             rd_ab;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] p;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/mma_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mma_ctrl
// Sequencer for loads and runs. Walks the result elements in row-major
// order and, for each, issues the C read, the depth_k operand reads, waits
// for the multiply pipeline to drain and then emits the element.
// ---------------------------------------------------------------------------
module mma_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire mma_pkg::op_t             s_op,
    input  wire logic [mma_pkg::IDX_W-1:0] m_last,
    input  wire logic [mma_pkg::IDX_W-1:0] k_last,
    input  wire logic [mma_pkg::IDX_W-1:0] n_last,
    input  wire mma_pkg::stat_t           stat,
    output mma_pkg::cmd_t                 cmd
);
    import mma_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic             elem_last;

    assign elem_last = (i_reg == m_last) && (j_reg == n_last);

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            p_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            p_reg     <= p_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.i      = i_reg;
        cmd.j      = j_reg;
        cmd.p      = p_reg;
        cmd.last   = elem_last;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_op)
                        OP_LOAD_A: cmd.wr_a = 1'b1;
                        OP_LOAD_B: cmd.wr_b = 1'b1;
                        OP_LOAD_C: cmd.wr_c = 1'b1;
                        OP_RUN: begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_READ_C;
                        end
                    endcase
                end
            end
            ST_READ_C: begin
                cmd.rd_c   = 1'b1;
                p_next     = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.rd_ab = 1'b1;
                if (p_reg == k_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ_C;
                        if (j_reg == n_last) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/mma_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mma_dpath
// Element stores for A, B and C, a registered multiply feeding one
// accumulator, rounding and saturation, and the result output register.
// ---------------------------------------------------------------------------
module mma_dpath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mma_pkg::in_item_t   s_payload,
    input  wire mma_pkg::cmd_t       cmd,
    output mma_pkg::stat_t           stat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mma_pkg::out_item_t       m_payload
);
    import mma_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam int QUO_W = ACC_W - FRAC_W;

    logic [VAL_W-1:0] a_mem [DEPTH];
    logic [VAL_W-1:0] b_mem [DEPTH];
    logic [VAL_W-1:0] c_mem [DEPTH];

    logic [ADDR_W-1:0] ld_addr, a_addr, b_addr, c_addr;

    logic signed [VAL_W-1:0]  a_q_reg, b_q_reg, c_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     rd_v_reg, mul_v_reg, c_v_reg;

    logic signed [QUO_W-1:0]  quot;
    logic                     ovf_pos, ovf_neg;
    logic signed [VAL_W-1:0]  result;

    logic      m_valid_reg;
    out_item_t m_payload_reg;

    assign ld_addr = {s_payload.row, s_payload.col};
    assign a_addr  = {cmd.i, cmd.p};
    assign b_addr  = {cmd.p, cmd.j};
    assign c_addr  = {cmd.i, cmd.j};

    // a store
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            a_mem[ld_addr] <= s_payload.element_value;
        end
        if (cmd.rd_ab) begin
            a_q_reg <= a_mem[a_addr];
        end
    end

    // b store
    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            b_mem[ld_addr] <= s_payload.element_value;
        end
        if (cmd.rd_ab) begin
            b_q_reg <= b_mem[b_addr];
        end
    end

    // c store: loaded from input, written back on emit
    always_ff @(posedge aclk) begin
        if (cmd.wr_c) begin
            c_mem[ld_addr] <= s_payload.element_value;
        end else if (cmd.emit) begin
            c_mem[c_addr] <= result;
        end
        if (cmd.rd_c) begin
            c_q_reg <= c_mem[c_addr];
        end
    end

    // pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            c_v_reg   <= 1'b0;
        end else begin
            rd_v_reg  <= cmd.rd_ab;
            mul_v_reg <= rd_v_reg;
            c_v_reg   <= cmd.rd_c;
        end
    end

    assign prod_next = a_q_reg * b_q_reg;

    // multiply stage
    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            prod_reg <= prod_next;
        end
    end

    // accumulator, preset with c << 8 plus the rounding half
    always_ff @(posedge aclk) begin
        if (c_v_reg) begin
            acc_reg <= {{(ACC_W-VAL_W-FRAC_W){c_q_reg[VAL_W-1]}}, c_q_reg,
                        1'b1, {(FRAC_W-1){1'b0}}};
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // floor shift and saturation
    assign quot    = acc_reg[ACC_W-1:FRAC_W];
    assign ovf_pos = !quot[QUO_W-1] && (|quot[QUO_W-2:VAL_W-1]);
    assign ovf_neg = quot[QUO_W-1] && !(&quot[QUO_W-2:VAL_W-1]);

    always_comb begin
        if (ovf_pos) begin
            result = VAL_MAX;
        end else if (ovf_neg) begin
            result = VAL_MIN;
        end else begin
            result = quot[VAL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_payload_reg.out_row     <= cmd.i;
            m_payload_reg.out_col     <= cmd.j;
            m_payload_reg.out_value   <= result;
            m_payload_reg.last_of_run <= cmd.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload      = m_payload_reg;
    assign stat.pipe_busy = rd_v_reg || mul_v_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

>>> hdl/matrix_multiply_accumulate.sv
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_multiply_accumulate
// C = C + A*B on signed Q8.8 elements held in three 8 x 8 stores.
// ---------------------------------------------------------------------------
// Load transactions write one element of A, B or C per cycle outside runs. A
// run transaction updates every active C element and emits it in row-major
// order, last_of_run marking the final one. Each element passes, on the
// single multiply-accumulate unit fed from one read port per store, through
// the C read, depth_k operand reads, pipeline drain, write-back and emit;
// output stalls hold the emit, and no new transaction is taken during a run.
// Sums are kept at full width, rounded half up and saturated to 16 bits.
// Size registers written as zero act as one and are capped at MAX_M, MAX_N
// and the smaller of MAX_K and 8. Stores are not cleared at reset: every
// element that a run uses must have been loaded first.
module matrix_multiply_accumulate #(
    parameter int MAX_M = 8,
    parameter int MAX_K = 8,
    parameter int MAX_N = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire mma_pkg::in_item_t            s_payload,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output mma_pkg::out_item_t                m_payload,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire mma_pkg::cfg_idx_t            cfg_index,
    input  wire logic [mma_pkg::SIZE_W-1:0]   cfg_data
);
    import mma_pkg::*;

    localparam int K_LIM_I = (MAX_K < 8) ? MAX_K : 8;
    localparam logic [SIZE_W-1:0] M_LIM = SIZE_W'(MAX_M);
    localparam logic [SIZE_W-1:0] K_LIM = SIZE_W'(K_LIM_I);
    localparam logic [SIZE_W-1:0] N_LIM = SIZE_W'(MAX_N);

    logic [SIZE_W-1:0] rows_m_reg, depth_k_reg, cols_n_reg;
    logic [IDX_W-1:0]  m_last, k_last, n_last;
    cmd_t              cmd;
    stat_t             stat;

    // size register to last index, zero acting as one
    function automatic logic [IDX_W-1:0] clamp_last(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] s;
        s = (v == '0) ? SIZE_W'(1) : ((v > lim) ? lim : v);
        return IDX_W'(s - SIZE_W'(1));
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= SIZE_W'(8);
            depth_k_reg <= SIZE_W'(8);
            cols_n_reg  <= SIZE_W'(8);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                CFG_DEPTH_K: depth_k_reg <= cfg_data;
                CFG_COLS_N:  cols_n_reg  <= cfg_data;
                CFG_NONE:    ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_last    = clamp_last(rows_m_reg, M_LIM);
    assign k_last    = clamp_last(depth_k_reg, K_LIM);
    assign n_last    = clamp_last(cols_n_reg, N_LIM);

    mma_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_payload.operation),
        .m_last  (m_last),
        .k_last  (k_last),
        .n_last  (n_last),
        .stat    (stat),
        .cmd     (cmd)
    );

    mma_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // an element is emitted only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("emit while output register is occupied");

    // the accumulator has taken every product before an emit
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !stat.pipe_busy)
        else $error("emit before multiply pipeline drained");

    // a run transaction blocks further input transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.operation == OP_RUN) |=> !s_ready)
        else $error("input accepted during a run");

    // the last element of a run returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> (s_ready && m_valid && m_payload.last_of_run))
        else $error("run did not end after its last element");
`endif

endmodule
`default_nettype wire
